/* sv/sito_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sito_pkg: shared types and constants of the strided index-to-offset block
// Widths, pipeline depth figures, register map codes and the stage record
// that flows through the divider chain.
// ----------------------------------------------------------------------------
package sito_pkg;

	// tensor shape
	localparam int NUM_DIMS    = 4;
	localparam int MAX_DIMS    = 4;
	localparam int ACTIVE_DIMS = (MAX_DIMS > NUM_DIMS) ? NUM_DIMS :
	                             ((MAX_DIMS < 1) ? 1 : MAX_DIMS);
	localparam int FIRST_DIM   = NUM_DIMS - ACTIVE_DIMS;

	// field widths
	localparam int SIZE_W   = 16;
	localparam int STRIDE_W = 24;
	localparam int INDEX_W  = 32;
	localparam int OFFSET_W = 48;
	localparam int PROD_W   = SIZE_W + STRIDE_W;

	// divider: quotient bits resolved per stage
	localparam int STEP_BITS   = 4;
	localparam int DIV_STAGES  = INDEX_W / STEP_BITS;
	localparam int DIM_LATENCY = DIV_STAGES + 2;
	localparam int LATENCY     = NUM_DIMS * DIM_LATENCY;
	localparam int CNT_W       = $clog2(LATENCY + 2);

	// configuration port
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	typedef enum logic [2:0] {
		REG_DIM0_SIZE,
		REG_DIM1_SIZE,
		REG_DIM2_SIZE,
		REG_DIM3_SIZE,
		REG_DIM0_STRIDE,
		REG_DIM1_STRIDE,
		REG_DIM2_STRIDE,
		REG_DIM3_STRIDE
	} reg_idx_t;

	// one pipeline slot: partial remainder, shifting dividend/quotient word, offset sum
	typedef struct packed {
		logic                valid;
		logic [SIZE_W-1:0]   part;
		logic [INDEX_W-1:0]  word;
		logic [OFFSET_W-1:0] acc;
	} sito_div_t;

endpackage

/* sv/sito_div_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sito_div_stage: one stage of the restoring divider
// Resolves STEP_BITS quotient bits of a 32 by 16 bit division and carries
// the offset sum alongside.
// ----------------------------------------------------------------------------
module sito_div_stage import sito_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  sito_div_t         cur,
	input  logic [SIZE_W-1:0] divisor,
	output sito_div_t         nxt
);

	logic                valid_s1;
	logic [SIZE_W-1:0]   part_s1;
	logic [INDEX_W-1:0]  word_s1;
	logic [OFFSET_W-1:0] acc_s1;
	logic [SIZE_W-1:0]   part_c;
	logic [INDEX_W-1:0]  word_c;

	// shift in dividend bits, subtract divisor where it fits
	always_comb begin
		logic [SIZE_W:0] trial;
		logic            fits;
		part_c = cur.part;
		word_c = cur.word;
		for (int i = 0; i < STEP_BITS; i++) begin
			trial = {part_c, word_c[INDEX_W-1]};
			fits  = (trial >= {1'b0, divisor});
			if (fits) begin
				part_c = SIZE_W'(trial - {1'b0, divisor});
			end else begin
				part_c = trial[SIZE_W-1:0];
			end
			word_c = {word_c[INDEX_W-2:0], fits};
		end
	end

	// advance the valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= cur.valid;
		end
	end

	// advance the payload
	always_ff @(posedge clk) begin
		if (adv) begin
			part_s1 <= part_c;
			word_s1 <= word_c;
			acc_s1  <= cur.acc;
		end
	end

	assign nxt = '{valid: valid_s1, part: part_s1, word: word_s1, acc: acc_s1};

endmodule

/* sv/sito_dim.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sito_dim: one tensor dimension
// Divides the remaining index by the dimension size over a chain of divider
// stages, multiplies the coordinate by the stride and adds it to the offset.
// ----------------------------------------------------------------------------
module sito_dim import sito_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                dim_on,
	input  logic [SIZE_W-1:0]   size,
	input  logic [STRIDE_W-1:0] stride,
	input  sito_div_t           dim_in,
	output sito_div_t           dim_out
);

	sito_div_t           chain [DIV_STAGES+1];
	logic [SIZE_W-1:0]   divisor;
	logic                valid_s1;
	logic [INDEX_W-1:0]  quot_s1;
	logic [OFFSET_W-1:0] acc_s1;
	logic [PROD_W-1:0]   prod_s1;
	logic                valid_s2;
	logic [INDEX_W-1:0]  quot_s2;
	logic [OFFSET_W-1:0] acc_s2;

	// a zero size or an unused dimension acts as size one
	assign divisor = (!dim_on || size == '0) ? SIZE_W'(1) : size;

	assign chain[0] = '{valid: dim_in.valid, part: '0, word: dim_in.word, acc: dim_in.acc};

	for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
		sito_div_stage u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.cur     (chain[s]),
			.divisor (divisor),
			.nxt     (chain[s+1])
		);
	end

	// hold valid bits of the multiply and add stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= chain[DIV_STAGES].valid;
			valid_s2 <= valid_s1;
		end
	end

	// multiply coordinate by stride, then accumulate
	always_ff @(posedge clk) begin
		if (adv) begin
			quot_s1 <= chain[DIV_STAGES].word;
			acc_s1  <= chain[DIV_STAGES].acc;
			prod_s1 <= PROD_W'(chain[DIV_STAGES].part) * PROD_W'(stride);
			quot_s2 <= quot_s1;
			acc_s2  <= acc_s1 + OFFSET_W'(prod_s1);
		end
	end

	assign dim_out = '{valid: valid_s2, part: '0, word: quot_s2, acc: acc_s2};

endmodule

/* sv/strided_index_to_offset.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strided_index_to_offset: strided tensor address generator
// Maps a row-major element index to the element offset in a strided source.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req_valid/req_ready with element_index; results leave on
//   rsp_valid/rsp_ready with source_offset, one result per request, in order.
//   Dimension sizes and strides are written over the APB port while idle.
// Pipeline: 40 register stages. A request accepted on an edge enters the first
//   stage, and rsp_valid is driven from the valid bit of the last one. Each
//   of the four dimensions takes 8 divider stages (4 quotient bits each), one
//   multiply stage and one add stage.
// Throughput: one request per cycle while not stalled; the whole pipeline advances together.
// Stall: while rsp_valid is high and rsp_ready low, every stage holds and
//   req_ready drops; nothing is lost or repeated.
// Reset: all valid bits clear; sizes reset to 1, strides to 0 except the
//   innermost stride, which resets to 1.
// ----------------------------------------------------------------------------
module strided_index_to_offset import sito_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  logic [INDEX_W-1:0]  element_index,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output logic [OFFSET_W-1:0] source_offset,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready
);

	logic [SIZE_W-1:0]   size_q   [NUM_DIMS];
	logic [STRIDE_W-1:0] stride_q [NUM_DIMS];
	sito_div_t           link [NUM_DIMS+1];
	logic                adv;
	logic                cfg_wr;
	reg_idx_t            reg_idx;
	logic [CNT_W-1:0]    inflight_q;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < NUM_DIMS; d++) begin
				size_q[d]   <= SIZE_W'(1);
				stride_q[d] <= '0;
			end
			stride_q[NUM_DIMS-1] <= STRIDE_W'(1);
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_DIM0_SIZE:   size_q[0]   <= pwdata[SIZE_W-1:0];
				REG_DIM1_SIZE:   size_q[1]   <= pwdata[SIZE_W-1:0];
				REG_DIM2_SIZE:   size_q[2]   <= pwdata[SIZE_W-1:0];
				REG_DIM3_SIZE:   size_q[3]   <= pwdata[SIZE_W-1:0];
				REG_DIM0_STRIDE: stride_q[0] <= pwdata[STRIDE_W-1:0];
				REG_DIM1_STRIDE: stride_q[1] <= pwdata[STRIDE_W-1:0];
				REG_DIM2_STRIDE: stride_q[2] <= pwdata[STRIDE_W-1:0];
				REG_DIM3_STRIDE: stride_q[3] <= pwdata[STRIDE_W-1:0];
				default: ;
			endcase
		end
	end

	// read back configuration
	always_comb begin
		case (reg_idx)
			REG_DIM0_SIZE:   prdata = DATA_W'(size_q[0]);
			REG_DIM1_SIZE:   prdata = DATA_W'(size_q[1]);
			REG_DIM2_SIZE:   prdata = DATA_W'(size_q[2]);
			REG_DIM3_SIZE:   prdata = DATA_W'(size_q[3]);
			REG_DIM0_STRIDE: prdata = DATA_W'(stride_q[0]);
			REG_DIM1_STRIDE: prdata = DATA_W'(stride_q[1]);
			REG_DIM2_STRIDE: prdata = DATA_W'(stride_q[2]);
			REG_DIM3_STRIDE: prdata = DATA_W'(stride_q[3]);
			default:         prdata = '0;
		endcase
	end

	// advance the pipeline unless a finished request is held
	assign adv       = !rsp_valid || rsp_ready;
	assign req_ready = adv;

	assign link[0] = '{valid: req_valid, part: '0, word: element_index, acc: '0};

	// innermost dimension first
	for (genvar j = 0; j < NUM_DIMS; j++) begin : g_dim
		localparam int D = NUM_DIMS - 1 - j;
		sito_dim u_dim (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.dim_on  (1'(D >= FIRST_DIM)),
			.size    (size_q[D]),
			.stride  (stride_q[D]),
			.dim_in  (link[j]),
			.dim_out (link[j+1])
		);
	end

	assign rsp_valid     = link[NUM_DIMS].valid;
	assign source_offset = link[NUM_DIMS].acc;

	// count requests in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + CNT_W'(req_valid && req_ready)
			                         - CNT_W'(rsp_valid && rsp_ready);
		end
	end

	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_W'(LATENCY))
		else $error("more requests in flight than pipeline stages");

	a_rsp_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> inflight_q != '0)
		else $error("response without a matching request");

	a_stall_blocks_req: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> inflight_q == $past(inflight_q))
		else $error("in-flight count changed during a stall");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for strided_index_to_offset
// Drives element indexes through the request channel under random idling and
// a long result stall, predicts each source offset from the current shape and
// strides, and compares results in order. Shape registers are rewritten over
// APB between phases, with the block drained.
// ----------------------------------------------------------------------------
module testbench import sito_pkg::*;;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_ready;
	logic [INDEX_W-1:0]  element_index = '0;
	logic                rsp_valid;
	logic                rsp_ready = 1'b0;
	logic [OFFSET_W-1:0] source_offset;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	strided_index_to_offset i_dut (.*);

	always #5 clk = ~clk;

	// shadow copy of the shape registers
	logic [SIZE_W-1:0]   shape_size [NUM_DIMS];
	logic [STRIDE_W-1:0] shape_stride [NUM_DIMS];

	logic [OFFSET_W-1:0] offset_queue [$];
	int unsigned         error_count = 0;
	int unsigned         result_count = 0;
	int unsigned         request_count = 0;
	bit                  calm = 1'b0;
	bit                  hold_off = 1'b0;

	// walk dimensions from innermost outward, wrapping in the outermost
	function automatic logic [OFFSET_W-1:0] offset_of(logic [INDEX_W-1:0] idx);
		logic [63:0]         rest;
		logic [63:0]         dim_sz;
		logic [OFFSET_W-1:0] sum;
		rest = 64'(idx);
		sum = '0;
		for (int d = NUM_DIMS - 1; d >= FIRST_DIM; d--) begin
			dim_sz = (shape_size[d] == 0) ? 64'd1 : 64'(shape_size[d]);
			sum += OFFSET_W'((rest % dim_sz) * 64'(shape_stride[d]));
			rest = rest / dim_sz;
		end
		return sum;
	endfunction

	task automatic write_reg(reg_idx_t r, logic [DATA_W-1:0] v);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= ADDR_W'(4 * int'(r)); pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (int'(r) < NUM_DIMS)
			shape_size[int'(r)] = v[SIZE_W-1:0];
		else
			shape_stride[int'(r) - NUM_DIMS] = v[STRIDE_W-1:0];
	endtask

	task automatic set_shape(input logic [SIZE_W-1:0] sz [NUM_DIMS],
	                         input logic [STRIDE_W-1:0] st [NUM_DIMS]);
		for (int d = 0; d < NUM_DIMS; d++) begin
			write_reg(reg_idx_t'(d), DATA_W'(sz[d]));
			write_reg(reg_idx_t'(d + NUM_DIMS), DATA_W'(st[d]));
		end
	endtask

	// offer one request, idling at random first; hold until accepted
	task automatic send_index(logic [INDEX_W-1:0] idx, logic [OFFSET_W-1:0] typed, bit has_typed);
		while (!calm && $urandom_range(99) < 37) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		element_index <= idx;
		do @(posedge clk); while (!req_ready);
		offset_queue.push_back(offset_of(idx));
		if (has_typed && typed !== offset_of(idx)) begin
			$display("%0t typed value disagrees: expected %h predicted %h", $time,
			         typed, offset_of(idx));
			error_count++;
		end
		request_count++;
	endtask

	// drop the request line and wait out the pipeline before touching registers
	task automatic drain();
		req_valid <= 1'b0;
		while (offset_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// receiver: random stalls, plus an optional long hold-off
	always @(posedge clk) begin
		if (hold_off)
			rsp_ready <= 1'b0;
		else
			rsp_ready <= calm || ($urandom_range(99) >= 37);
	end

	// compare each result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			result_count++;
			if (offset_queue.size() == 0) begin
				$display("%0t unexpected result: actual %h", $time, source_offset);
				error_count++;
			end else begin
				if (source_offset !== offset_queue[0]) begin
					$display("%0t source_offset mismatch: expected %h actual %h",
					         $time, offset_queue[0], source_offset);
					error_count++;
				end
				void'(offset_queue.pop_front());
			end
		end
	end

	typedef struct {
		logic [INDEX_W-1:0]  idx;
		logic [OFFSET_W-1:0] typed;
		bit                  has_typed;
	} index_row_t;

	initial begin
		#50_000_000;
		$display("FAIL strided_index_to_offset");
		$finish;
	end

	initial begin
		logic [SIZE_W-1:0]   sz [NUM_DIMS];
		logic [STRIDE_W-1:0] st [NUM_DIMS];
		index_row_t          rows [$];
		logic [INDEX_W-1:0]  idx;
		int                  hold_cycles;

		shape_size = '{16'd1, 16'd1, 16'd1, 16'd1};
		shape_stride = '{24'd0, 24'd0, 24'd0, 24'd1};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset every size is one, so every coordinate and the offset are zero
		rows = '{'{32'd0, 48'd0, 1}, '{32'd1, 48'd0, 1},
		         '{32'hFFFF_FFFF, 48'd0, 1}, '{32'h8000_0000, 48'd0, 1}};
		foreach (rows[i]) send_index(rows[i].idx, rows[i].typed, rows[i].has_typed);
		drain();

		// extremes: full sizes and strides
		sz = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
		st = '{24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF};
		set_shape(sz, st);
		rows = '{'{32'd0, 48'd0, 1}, '{32'hFFFF_FFFF, 0, 0}, '{32'h0000_FFFE, 0, 0},
		         '{32'h0001_0000, 0, 0}, '{32'hFFFE_FFFF, 0, 0}, '{32'h5555_AAAA, 0, 0}};
		foreach (rows[i]) send_index(rows[i].idx, rows[i].typed, rows[i].has_typed);
		drain();
		sz = '{16'd3, 16'd0, 16'd5, 16'd7};
		st = '{24'd1000, 24'd77, 24'd0, 24'd2};
		set_shape(sz, st);
		// wrap past the tensor and cross each dimension boundary
		rows = '{'{32'd6, 48'd12, 1}, '{32'd7, 0, 0}, '{32'd34, 0, 0}, '{32'd35, 48'd1000, 1},
		         '{32'd104, 0, 0}, '{32'd105, 48'd0, 1}, '{32'd106, 0, 0},
		         '{32'hFFFF_FFFF, 0, 0}, '{32'h1234_5678, 0, 0}};
		foreach (rows[i]) send_index(rows[i].idx, rows[i].typed, rows[i].has_typed);
		drain();

		// random phases with new shapes; small sizes mostly, some full-range
		for (int ph = 0; ph < 12; ph++) begin
			for (int d = 0; d < NUM_DIMS; d++) begin
				sz[d] = (ph % 4 == 3) ? SIZE_W'($urandom) : SIZE_W'($urandom_range(0, 20));
				st[d] = (ph % 3 == 2) ? STRIDE_W'($urandom) : STRIDE_W'($urandom_range(0, 300));
			end
			set_shape(sz, st);
			calm = (ph == 5);
			if (ph == 7) begin
				// long result stall while requests keep coming
				fork
					begin
						hold_off = 1'b1;
						hold_cycles = 0;
						while (hold_cycles < 200) begin
							@(posedge clk);
							hold_cycles++;
						end
						hold_off = 1'b0;
					end
				join_none
			end
			for (int n = 0; n < 100; n++) begin
				case ($urandom_range(3))
					0: idx = $urandom;
					1: idx = $urandom_range(0, 4000);
					default: idx = INDEX_W'($urandom_range(0,
					                 int'(sz[0]) * int'(sz[1]) * int'(sz[2]) * int'(sz[3]) + 5));
				endcase
				send_index(idx, '0, 0);
			end
			calm = 1'b0;
			drain();
		end

		$display("Covered %0d requests and %0d results over reset, extreme and 12 random shapes.",
		         request_count, result_count);
		if (error_count == 0 && offset_queue.size() == 0)
			$display("PASS strided_index_to_offset");
		else
			$display("FAIL strided_index_to_offset");
		$finish;
	end

endmodule
